// File: sv/trm_pkg.sv
// ----------------------------------------------------------------------------
// trm_pkg
// Shared types and constants of the three channel RMS meter core.
// ----------------------------------------------------------------------------
package trm_pkg;

   localparam int SUM_W       = 34;
   localparam int ROOT_W      = SUM_W / 2;
   localparam int GAIN_W      = 24;
   localparam int CENTER_W    = 12;
   localparam int OFFSET_W    = 12;
   localparam int VALUE_W     = 16;
   localparam int PROD_W      = ROOT_W + GAIN_W;
   localparam int FRAC_W      = 16;
   localparam int DIV_STEPS   = SUM_W;
   localparam int SQRT_STEPS  = ROOT_W;
   localparam int STEP_W      = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int CHAN_COUNT  = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CENTER_CODE      = 3'd0,
      REG_OFFSET_CODE      = 3'd1,
      REG_VOLTAGE_GAIN     = 3'd2,
      REG_CURRENT_GAIN     = 3'd3,
      REG_VOLTAGE_FLOOR    = 3'd4,
      REG_CURRENT_FLOOR    = 3'd5,
      REG_SELECT_THRESHOLD = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      CHAN_ONE   = 2'd0,
      CHAN_TWO   = 2'd1,
      CHAN_THREE = 2'd2,
      CHAN_DONE  = 2'd3
   } chan_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_SOLVE,
      ST_SOLVE_WAIT,
      ST_OUTPUT
   } top_state_type;

   typedef enum logic [2:0] {
      SV_IDLE,
      SV_DIV,
      SV_SQRT,
      SV_MUL,
      SV_FIN
   } solve_state_type;

   typedef struct packed {
      logic start;
      logic clear;
   } acc_ctrl_type;

   typedef struct packed {
      logic                 done;
      logic [VALUE_W-1:0]   value;
   } solve_stat_type;

endpackage

// File: sv/trm_accum.sv
// ----------------------------------------------------------------------------
// trm_accum
// Sum of squares per channel, one shared squarer stepped over the channels.
// ----------------------------------------------------------------------------
module trm_accum
   import trm_pkg::*;
#(
   parameter int CODE_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  acc_ctrl_type         ctrl,
   input  logic [CENTER_W-1:0]  center,
   input  logic [CODE_BITS-1:0] code_one,
   input  logic [CODE_BITS-1:0] code_two,
   input  logic [CODE_BITS-1:0] code_three,
   output logic                 busy,
   output logic [SUM_W-1:0]     sum_one,
   output logic [SUM_W-1:0]     sum_two,
   output logic [SUM_W-1:0]     sum_three
);

   localparam int DIFF_W = (CODE_BITS > CENTER_W) ? CODE_BITS : CENTER_W;
   localparam int SQ_W   = 2 * DIFF_W;

   logic [CODE_BITS-1:0] code_ff [CHAN_COUNT];
   chan_type             phase_ff;
   logic                 busy_ff;
   logic [SQ_W-1:0]      sq_ff;
   logic [SUM_W-1:0]     sum_ff [CHAN_COUNT];

   logic [CODE_BITS-1:0] sel_code;
   logic [DIFF_W-1:0]    code_ext;
   logic [DIFF_W-1:0]    center_ext;
   logic [DIFF_W-1:0]    diff;
   logic [SUM_W-1:0]     acc_sel;
   logic [SUM_W:0]       acc_sum;
   logic [SUM_W-1:0]     acc_in;

   always_comb begin
      unique case (phase_ff)
         CHAN_ONE:   sel_code = code_ff[0];
         CHAN_TWO:   sel_code = code_ff[1];
         CHAN_THREE: sel_code = code_ff[2];
         default:    sel_code = '0;
      endcase
      code_ext   = DIFF_W'(sel_code);
      center_ext = DIFF_W'(center);
      diff       = (code_ext >= center_ext) ? (code_ext - center_ext) : (center_ext - code_ext);
      unique case (phase_ff)
         CHAN_TWO:   acc_sel = sum_ff[0];
         CHAN_THREE: acc_sel = sum_ff[1];
         CHAN_DONE:  acc_sel = sum_ff[2];
         default:    acc_sel = '0;
      endcase
      acc_sum = {1'b0, acc_sel} + (SUM_W+1)'(sq_ff);
      acc_in  = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= CHAN_ONE;
         for (int i = 0; i < CHAN_COUNT; i++) begin
            sum_ff[i] <= '0;
         end
      end else if (ctrl.clear) begin
         busy_ff  <= 1'b0;
         phase_ff <= CHAN_ONE;
         for (int i = 0; i < CHAN_COUNT; i++) begin
            sum_ff[i] <= '0;
         end
      end else if (ctrl.start) begin
         busy_ff  <= 1'b1;
         phase_ff <= CHAN_ONE;
      end else if (busy_ff) begin
         unique case (phase_ff)
            CHAN_ONE:   phase_ff <= CHAN_TWO;
            CHAN_TWO: begin
               phase_ff  <= CHAN_THREE;
               sum_ff[0] <= acc_in;
            end
            CHAN_THREE: begin
               phase_ff  <= CHAN_DONE;
               sum_ff[1] <= acc_in;
            end
            CHAN_DONE: begin
               phase_ff  <= CHAN_ONE;
               sum_ff[2] <= acc_in;
               busy_ff   <= 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         code_ff[0] <= code_one;
         code_ff[1] <= code_two;
         code_ff[2] <= code_three;
      end
      sq_ff <= diff * diff;
   end

   assign busy      = busy_ff;
   assign sum_one   = sum_ff[0];
   assign sum_two   = sum_ff[1];
   assign sum_three = sum_ff[2];

endmodule

// File: sv/trm_solver.sv
// ----------------------------------------------------------------------------
// trm_solver
// Mean, square root, offset and gain of one channel on a shared subtractor.
// ----------------------------------------------------------------------------
module trm_solver
   import trm_pkg::*;
#(
   parameter int COUNT_W = 13
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SUM_W-1:0]     sum,
   input  logic [COUNT_W-1:0]   count,
   input  logic [GAIN_W-1:0]    gain,
   input  logic [OFFSET_W-1:0]  offset,
   input  logic [VALUE_W-1:0]   floor_val,
   output solve_stat_type       stat
);

   localparam int SUB_W   = (COUNT_W + 1 > ROOT_W + 3) ? COUNT_W + 1 : ROOT_W + 3;
   localparam int SCALE_W = PROD_W + 1 - FRAC_W;

   solve_state_type      state_ff, state_in;
   logic [STEP_W-1:0]    step_ff;
   logic [SUM_W-1:0]     q_ff;
   logic [SUB_W-1:0]     rem_ff;
   logic [ROOT_W-1:0]    root_ff;
   logic [PROD_W-1:0]    prod_ff;

   logic [SUB_W-1:0]     sub_a;
   logic [SUB_W-1:0]     sub_b;
   logic [SUB_W:0]       sub_res;
   logic                 borrow;
   logic [ROOT_W-1:0]    offset_ext;
   logic [ROOT_W-1:0]    dval;
   logic [PROD_W:0]      rounded;
   logic [SCALE_W-1:0]   scaled;
   logic [VALUE_W-1:0]   sat;

   always_comb begin
      unique case (state_ff)
         SV_SQRT: begin
            sub_a = {rem_ff[SUB_W-3:0], q_ff[SUM_W-1:SUM_W-2]};
            sub_b = SUB_W'({root_ff, 2'b01});
         end
         default: begin
            sub_a = {rem_ff[SUB_W-2:0], q_ff[SUM_W-1]};
            sub_b = SUB_W'(count);
         end
      endcase
      sub_res = {1'b0, sub_a} - {1'b0, sub_b};
      borrow  = sub_res[SUB_W];
   end

   always_comb begin
      offset_ext = ROOT_W'(offset);
      dval       = (root_ff > offset_ext) ? (root_ff - offset_ext) : '0;
      rounded    = {1'b0, prod_ff} + (PROD_W+1)'(1 << (FRAC_W - 1));
      scaled     = rounded[PROD_W:FRAC_W];
      sat        = (|scaled[SCALE_W-1:VALUE_W]) ? '1 : scaled[VALUE_W-1:0];
      stat.done  = (state_ff == SV_FIN);
      stat.value = (sat < floor_val) ? '0 : sat;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SV_IDLE: begin
            if (start) begin
               state_in = (count == '0) ? SV_SQRT : SV_DIV;
            end
         end
         SV_DIV:  if (step_ff == '0) state_in = SV_SQRT;
         SV_SQRT: if (step_ff == '0) state_in = SV_MUL;
         SV_MUL:  state_in = SV_FIN;
         SV_FIN:  state_in = SV_IDLE;
         default: state_in = SV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         SV_IDLE: begin
            rem_ff  <= '0;
            root_ff <= '0;
            if (count == '0) begin
               q_ff    <= '0;
               step_ff <= STEP_W'(SQRT_STEPS - 1);
            end else begin
               q_ff    <= sum;
               step_ff <= STEP_W'(DIV_STEPS - 1);
            end
         end
         SV_DIV: begin
            q_ff <= {q_ff[SUM_W-2:0], ~borrow};
            if (step_ff == '0) begin
               rem_ff  <= '0;
               step_ff <= STEP_W'(SQRT_STEPS - 1);
            end else begin
               rem_ff  <= borrow ? sub_a : sub_res[SUB_W-1:0];
               step_ff <= step_ff - 1'b1;
            end
         end
         SV_SQRT: begin
            q_ff    <= {q_ff[SUM_W-3:0], 2'b00};
            rem_ff  <= borrow ? sub_a : sub_res[SUB_W-1:0];
            root_ff <= {root_ff[ROOT_W-2:0], ~borrow};
            step_ff <= step_ff - 1'b1;
         end
         SV_MUL: begin
            prod_ff <= dval * gain;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: sv/three_channel_rms_meter_core.sv
// ----------------------------------------------------------------------------
// three_channel_rms_meter_core
// True RMS of two voltage channels and one current channel over a window.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake          | Payload
//   req     | in        | req_valid/stall    | ch1..ch3 codes, last
//   rsp     | out       | rsp_valid/stall    | voltage_one/two, current_ma, active
//   csr     | in        | csr_write          | csr_index, csr_wdata
//
// A frame word is accepted from idle, stepped over the channels on the shared
// squarer, and the core then returns to idle.
// After a last frame each channel is solved in turn (a start, 34 divide steps,
// 17 root steps, a multiply and a finish), and the result word is loaded once
// the response side is free.
// Reset is synchronous; no clearing pass is needed after it.
// A pending result word is held while rsp_stall is high and new frames are taken.
// ----------------------------------------------------------------------------
module three_channel_rms_meter_core
   import trm_pkg::*;
#(
   parameter int MAX_FRAMES = 4096,
   parameter int CODE_BITS  = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CODE_BITS-1:0]   req_ch1_code,
   input  logic [CODE_BITS-1:0]   req_ch2_code,
   input  logic [CODE_BITS-1:0]   req_ch3_code,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_W-1:0]     rsp_voltage_one,
   output logic [VALUE_W-1:0]     rsp_voltage_two,
   output logic [VALUE_W-1:0]     rsp_current_ma,
   output logic [VALUE_W-1:0]     rsp_active_voltage,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COUNT_W = $clog2(MAX_FRAMES + 1);

   top_state_type         state_ff, state_in;
   chan_type              chan_ff, chan_in;
   logic                  last_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [VALUE_W-1:0]    res_ff [CHAN_COUNT];
   logic                  rsp_valid_ff;
   logic [VALUE_W-1:0]    rsp_one_ff, rsp_two_ff, rsp_cur_ff, rsp_act_ff;

   logic [CENTER_W-1:0]   center_ff;
   logic [OFFSET_W-1:0]   offset_ff;
   logic [GAIN_W-1:0]     vgain_ff;
   logic [GAIN_W-1:0]     igain_ff;
   logic [VALUE_W-1:0]    vfloor_ff;
   logic [VALUE_W-1:0]    ifloor_ff;
   logic [VALUE_W-1:0]    thresh_ff;

   logic                  accept;
   logic                  full;
   logic                  load_rsp;
   logic                  solve_start;
   acc_ctrl_type          acc_ctrl;
   logic                  acc_busy;
   logic [SUM_W-1:0]      sum_one, sum_two, sum_three;
   logic [SUM_W-1:0]      solve_sum;
   logic [GAIN_W-1:0]     solve_gain;
   logic [VALUE_W-1:0]    solve_floor;
   solve_stat_type        solve_stat;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff >= COUNT_W'(MAX_FRAMES));

   always_comb begin
      state_in       = state_ff;
      chan_in        = chan_ff;
      solve_start    = 1'b0;
      load_rsp       = 1'b0;
      acc_ctrl.start = accept && !full;
      acc_ctrl.clear = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (!acc_busy) begin
               chan_in  = CHAN_ONE;
               state_in = last_ff ? ST_SOLVE : ST_IDLE;
            end
         end
         ST_SOLVE: begin
            solve_start = 1'b1;
            state_in    = ST_SOLVE_WAIT;
         end
         ST_SOLVE_WAIT: begin
            if (solve_stat.done) begin
               if (chan_ff == CHAN_THREE) begin
                  state_in = ST_OUTPUT;
               end else begin
                  chan_in  = chan_type'(chan_ff + 1'b1);
                  state_in = ST_SOLVE;
               end
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp       = 1'b1;
               acc_ctrl.clear = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= CHAN_ONE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         center_ff    <= CENTER_W'(2048);
         offset_ff    <= OFFSET_W'(1018);
         vgain_ff     <= GAIN_W'(658733);
         igain_ff     <= GAIN_W'(1319991);
         vfloor_ff    <= VALUE_W'(320);
         ifloor_ff    <= VALUE_W'(205);
         thresh_ff    <= VALUE_W'(800);
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         if (load_rsp) begin
            count_ff <= '0;
         end else if (accept && !full) begin
            count_ff <= count_ff + 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            unique case (csr_index)
               REG_CENTER_CODE:      center_ff <= csr_wdata[CENTER_W-1:0];
               REG_OFFSET_CODE:      offset_ff <= csr_wdata[OFFSET_W-1:0];
               REG_VOLTAGE_GAIN:     vgain_ff  <= csr_wdata[GAIN_W-1:0];
               REG_CURRENT_GAIN:     igain_ff  <= csr_wdata[GAIN_W-1:0];
               REG_VOLTAGE_FLOOR:    vfloor_ff <= csr_wdata[VALUE_W-1:0];
               REG_CURRENT_FLOOR:    ifloor_ff <= csr_wdata[VALUE_W-1:0];
               REG_SELECT_THRESHOLD: thresh_ff <= csr_wdata[VALUE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= req_last;
      end
      if (state_ff == ST_SOLVE_WAIT && solve_stat.done) begin
         unique case (chan_ff)
            CHAN_ONE:   res_ff[0] <= solve_stat.value;
            CHAN_TWO:   res_ff[1] <= solve_stat.value;
            default:    res_ff[2] <= solve_stat.value;
         endcase
      end
      if (load_rsp) begin
         rsp_one_ff <= res_ff[0];
         rsp_two_ff <= res_ff[1];
         rsp_cur_ff <= res_ff[2];
         rsp_act_ff <= (res_ff[0] > thresh_ff) ? res_ff[0] : res_ff[1];
      end
   end

   always_comb begin
      unique case (chan_ff)
         CHAN_ONE: begin
            solve_sum   = sum_one;
            solve_gain  = vgain_ff;
            solve_floor = vfloor_ff;
         end
         CHAN_TWO: begin
            solve_sum   = sum_two;
            solve_gain  = vgain_ff;
            solve_floor = vfloor_ff;
         end
         default: begin
            solve_sum   = sum_three;
            solve_gain  = igain_ff;
            solve_floor = ifloor_ff;
         end
      endcase
   end

   trm_accum #(
      .CODE_BITS (CODE_BITS)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (acc_ctrl),
      .center     (center_ff),
      .code_one   (req_ch1_code),
      .code_two   (req_ch2_code),
      .code_three (req_ch3_code),
      .busy       (acc_busy),
      .sum_one    (sum_one),
      .sum_two    (sum_two),
      .sum_three  (sum_three)
   );

   trm_solver #(
      .COUNT_W (COUNT_W)
   ) u_solver (
      .clock     (clock),
      .reset     (reset),
      .start     (solve_start),
      .sum       (solve_sum),
      .count     (count_ff),
      .gain      (solve_gain),
      .offset    (offset_ff),
      .floor_val (solve_floor),
      .stat      (solve_stat)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_voltage_one    = rsp_one_ff;
   assign rsp_voltage_two    = rsp_two_ff;
   assign rsp_current_ma     = rsp_cur_ff;
   assign rsp_active_voltage = rsp_act_ff;

endmodule

// File: tb/sv/tb_three_channel_rms_meter_core.sv
// ----------------------------------------------------------------------------
// tb_three_channel_rms_meter_core
// Self-checking testbench of the three channel RMS meter core.
// Frame words are driven through the request channel. A predictor tracks
// the squared-code sums and the register settings, and computes each RMS
// result word when a last frame is accepted. Response words are compared
// field by field, in order, with the predicted words. The run covers reset
// settings, register extremes, a long window of full-scale codes, a long
// response hold-off, and random windows under random idling.
// ----------------------------------------------------------------------------
module tb_three_channel_rms_meter_core
   import trm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CODE_W          = 12;
   localparam int          WINDOW_MAX      = 4096;
   localparam int          LONG_WINDOW     = 40;
   localparam int          SETTLE_CYCLES   = 200;
   localparam int          HOLD_OFF_CYCLES = 1500;
   localparam int          WATCHDOG_LIMIT  = 20000;
   localparam int          PHASE_FRAMES    = 100;
   localparam longint unsigned SUM_LIMIT   = (64'd1 << SUM_W) - 64'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct {
      logic [CODE_W-1:0] ch1;
      logic [CODE_W-1:0] ch2;
      logic [CODE_W-1:0] ch3;
      logic              last;
   } frame_word_type;

   typedef struct {
      logic [VALUE_W-1:0] voltage_one;
      logic [VALUE_W-1:0] voltage_two;
      logic [VALUE_W-1:0] current_ma;
      logic [VALUE_W-1:0] active_voltage;
   } rms_word_type;

   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   req_valid          = 1'b0;
   logic                   req_stall;
   logic [CODE_W-1:0]      req_ch1_code       = '0;
   logic [CODE_W-1:0]      req_ch2_code       = '0;
   logic [CODE_W-1:0]      req_ch3_code       = '0;
   logic                   req_last           = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall          = 1'b0;
   logic [VALUE_W-1:0]     rsp_voltage_one;
   logic [VALUE_W-1:0]     rsp_voltage_two;
   logic [VALUE_W-1:0]     rsp_current_ma;
   logic [VALUE_W-1:0]     rsp_active_voltage;
   logic                   csr_write          = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index          = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata          = '0;

   // Register shadow of the meter.
   logic [CENTER_W-1:0]    cfg_center         = 12'd2048;
   logic [OFFSET_W-1:0]    cfg_offset         = 12'd1018;
   logic [GAIN_W-1:0]      cfg_voltage_gain   = 24'd658733;
   logic [GAIN_W-1:0]      cfg_current_gain   = 24'd1319991;
   logic [VALUE_W-1:0]     cfg_voltage_floor  = 16'd320;
   logic [VALUE_W-1:0]     cfg_current_floor  = 16'd205;
   logic [VALUE_W-1:0]     cfg_threshold      = 16'd800;

   // Window state of the predictor.
   longint unsigned        sq_sum_one         = 0;
   longint unsigned        sq_sum_two         = 0;
   longint unsigned        sq_sum_three       = 0;
   longint unsigned        frames_in_window   = 0;

   rms_word_type           rms_expected[$];

   int                     send_idle_pct      = 0;
   int                     recv_stall_pct     = 0;
   int unsigned            hold_off_left      = 0;
   int                     frames_sent        = 0;
   int                     results_checked    = 0;
   int                     error_count        = 0;
   int                     quiet_cycles       = 0;

   three_channel_rms_meter_core #(
      .MAX_FRAMES (WINDOW_MAX),
      .CODE_BITS  (CODE_W)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_ch1_code       (req_ch1_code),
      .req_ch2_code       (req_ch2_code),
      .req_ch3_code       (req_ch3_code),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_voltage_one    (rsp_voltage_one),
      .rsp_voltage_two    (rsp_voltage_two),
      .rsp_current_ma     (rsp_current_ma),
      .rsp_active_voltage (rsp_active_voltage),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint unsigned add_code_square(longint unsigned sum,
                                                       logic [CODE_W-1:0] code);
      longint unsigned delta;
      longint unsigned total;
      delta = (code >= cfg_center) ? 64'(code - cfg_center) : 64'(cfg_center - code);
      total = sum + delta * delta;
      return (total > SUM_LIMIT) ? SUM_LIMIT : total;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = ROOT_W; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x) root = trial;
      end
      return root;
   endfunction

   function automatic logic [VALUE_W-1:0] scaled_rms(longint unsigned sum,
                                                     longint unsigned gain,
                                                     longint unsigned floor_lim);
      longint unsigned mean_sq;
      longint unsigned root;
      longint unsigned excess;
      longint unsigned scaled;
      mean_sq = (frames_in_window != 0) ? sum / frames_in_window : 64'd0;
      root    = floor_sqrt(mean_sq);
      excess  = (root > 64'(cfg_offset)) ? root - 64'(cfg_offset) : 64'd0;
      scaled  = (excess * gain + 64'd32768) >> FRAC_W;
      if (scaled > 64'd65535) scaled = 64'd65535;
      if (scaled < floor_lim) scaled = 64'd0;
      return scaled[VALUE_W-1:0];
   endfunction

   function automatic void accumulate_frame(logic [CODE_W-1:0] ch1, logic [CODE_W-1:0] ch2,
                                            logic [CODE_W-1:0] ch3, logic last);
      rms_word_type w;
      if (frames_in_window < WINDOW_MAX) begin
         sq_sum_one   = add_code_square(sq_sum_one, ch1);
         sq_sum_two   = add_code_square(sq_sum_two, ch2);
         sq_sum_three = add_code_square(sq_sum_three, ch3);
         frames_in_window++;
      end
      if (last) begin
         w.voltage_one    = scaled_rms(sq_sum_one, 64'(cfg_voltage_gain),
                                       64'(cfg_voltage_floor));
         w.voltage_two    = scaled_rms(sq_sum_two, 64'(cfg_voltage_gain),
                                       64'(cfg_voltage_floor));
         w.current_ma     = scaled_rms(sq_sum_three, 64'(cfg_current_gain),
                                       64'(cfg_current_floor));
         w.active_voltage = (w.voltage_one > cfg_threshold) ? w.voltage_one : w.voltage_two;
         rms_expected.push_back(w);
         sq_sum_one       = 0;
         sq_sum_two       = 0;
         sq_sum_three     = 0;
         frames_in_window = 0;
      end
   endfunction

   task automatic check_field(input string name, input logic [VALUE_W-1:0] expected,
                              input logic [VALUE_W-1:0] actual);
      if (actual !== expected) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, expected,
                  actual);
      end
   endtask

   task automatic check_rms_word();
      rms_word_type w;
      if (rms_expected.size() == 0) begin
         error_count++;
         $display("%0t ns: result word with none expected, got %0d %0d %0d %0d", $time,
                  rsp_voltage_one, rsp_voltage_two, rsp_current_ma, rsp_active_voltage);
      end else begin
         w = rms_expected.pop_front();
         check_field("voltage_one", w.voltage_one, rsp_voltage_one);
         check_field("voltage_two", w.voltage_two, rsp_voltage_two);
         check_field("current_ma", w.current_ma, rsp_current_ma);
         check_field("active_voltage", w.active_voltage, rsp_active_voltage);
         results_checked++;
      end
   endtask

   // Monitor, scoreboard and watchdog share the sampling edge.
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (req_valid && !req_stall) begin
            accumulate_frame(req_ch1_code, req_ch2_code, req_ch3_code, req_last);
            quiet_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            check_rms_word();
            quiet_cycles = 0;
         end
         if (csr_write) quiet_cycles = 0;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: watchdog expired with %0d result words outstanding", $time,
                     rms_expected.size());
            $display("tb_three_channel_rms_meter_core failed");
            $finish;
         end
      end
   end

   // Response side: random stalls, or a counted hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_frame(input frame_word_type f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_ch1_code <= f.ch1;
      req_ch2_code <= f.ch2;
      req_ch3_code <= f.ch3;
      req_last     <= f.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frames_sent++;
   endtask

   task automatic send_codes(input logic [CODE_W-1:0] ch1, input logic [CODE_W-1:0] ch2,
                             input logic [CODE_W-1:0] ch3, input logic last);
      frame_word_type f;
      f.ch1  = ch1;
      f.ch2  = ch2;
      f.ch3  = ch3;
      f.last = last;
      send_frame(f);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (rms_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_CENTER_CODE:      cfg_center        = data[CENTER_W-1:0];
         REG_OFFSET_CODE:      cfg_offset        = data[OFFSET_W-1:0];
         REG_VOLTAGE_GAIN:     cfg_voltage_gain  = data[GAIN_W-1:0];
         REG_CURRENT_GAIN:     cfg_current_gain  = data[GAIN_W-1:0];
         REG_VOLTAGE_FLOOR:    cfg_voltage_floor = data[VALUE_W-1:0];
         REG_CURRENT_FLOOR:    cfg_current_floor = data[VALUE_W-1:0];
         REG_SELECT_THRESHOLD: cfg_threshold     = data[VALUE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_meter(input logic [CENTER_W-1:0] center,
                                input logic [OFFSET_W-1:0] offset,
                                input logic [GAIN_W-1:0] v_gain, input logic [GAIN_W-1:0] i_gain,
                                input logic [VALUE_W-1:0] v_floor,
                                input logic [VALUE_W-1:0] i_floor,
                                input logic [VALUE_W-1:0] threshold);
      write_csr(REG_CENTER_CODE, CSR_DATA_W'(center));
      write_csr(REG_OFFSET_CODE, CSR_DATA_W'(offset));
      write_csr(REG_VOLTAGE_GAIN, v_gain);
      write_csr(REG_CURRENT_GAIN, i_gain);
      write_csr(REG_VOLTAGE_FLOOR, CSR_DATA_W'(v_floor));
      write_csr(REG_CURRENT_FLOOR, CSR_DATA_W'(i_floor));
      write_csr(REG_SELECT_THRESHOLD, CSR_DATA_W'(threshold));
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CODE_W-1:0] code_near(int amp);
      int v;
      v = int'(cfg_center) + int'($urandom_range(2 * amp)) - amp;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[CODE_W-1:0];
   endfunction

   task automatic send_random_window();
      frame_word_type f;
      int             len;
      int             amp1;
      int             amp2;
      int             amp3;
      len  = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
      amp1 = $urandom_range(2047);
      amp2 = $urandom_range(2047);
      amp3 = $urandom_range(2047);
      for (int i = 0; i < len; i++) begin
         f.ch1  = ($urandom_range(9) == 0) ? CODE_W'($urandom) : code_near(amp1);
         f.ch2  = ($urandom_range(9) == 0) ? CODE_W'($urandom) : code_near(amp2);
         f.ch3  = ($urandom_range(9) == 0) ? CODE_W'($urandom) : code_near(amp3);
         f.last = (i == len - 1);
         send_frame(f);
      end
   endtask

   task automatic test_reset_settings();
      send_codes(12'd2048, 12'd2048, 12'd2048, 1'b1);
      send_codes(12'd4095, 12'd0, 12'd2048, 1'b1);
      send_codes(12'd0, 12'd4095, 12'd4095, 1'b1);
      send_codes(12'd4095, 12'd2048, 12'd0, 1'b0);
      send_codes(12'd0, 12'd2048, 12'd4095, 1'b1);
      send_codes(12'd2100, 12'd4095, 12'd3000, 1'b1);
      send_codes(12'hAAA, 12'h555, 12'hAAA, 1'b1);
      send_codes(12'h555, 12'hAAA, 12'h555, 1'b1);
      settle();
   endtask

   task automatic test_register_extremes();
      program_meter(12'd0, 12'd0, 24'hFFFFFF, 24'hFFFFFF, 16'd0, 16'd0, 16'd0);
      send_codes(12'd0, 12'd0, 12'd0, 1'b1);
      send_codes(12'd1, 12'd1, 12'd1, 1'b1);
      send_codes(12'd4095, 12'd4095, 12'd4095, 1'b1);
      settle();
      program_meter(12'd4095, 12'd4095, 24'd0, 24'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // A write to an index with no register behind it must change nothing.
      write_csr(REG_UNUSED, 24'hABCDEF);
      csr_write <= 1'b0;
      @(posedge clock);
      send_codes(12'd0, 12'd4095, 12'd2000, 1'b1);
      settle();
      program_meter(12'd4095, 12'd0, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_codes(12'd0, 12'd4095, 12'd4000, 1'b1);
      send_codes(12'd1, 12'd0, 12'd1, 1'b1);
      send_codes(12'd0, 12'd0, 12'd0, 1'b0);
      send_codes(12'd4095, 12'd4095, 12'd0, 1'b1);
      settle();
   endtask

   // Full-scale codes against a zero center give the largest squares and a
   // wide mean to divide and take the root of.
   task automatic test_long_window();
      program_meter(12'd0, 12'd0, 24'd658733, 24'd1319991, 16'd0, 16'd0, 16'd800);
      for (int i = 0; i < LONG_WINDOW; i++) begin
         send_codes(12'd4095, 12'd1000, CODE_W'($urandom), i == LONG_WINDOW - 1);
      end
      send_codes(12'd4095, 12'd1000, 12'd3, 1'b0);
      send_codes(12'd1, 12'd2000, 12'd5, 1'b1);
      settle();
   endtask

   task automatic test_response_hold_off();
      program_meter(12'd2048, 12'd1018, 24'd658733, 24'd1319991, 16'd320, 16'd205, 16'd800);
      hold_off_left = HOLD_OFF_CYCLES;
      for (int w = 0; w < 12; w++) begin
         send_codes(CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom), 1'b0);
         send_codes(CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom), 1'b0);
         send_codes(CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom), 1'b1);
      end
      settle();
   endtask

   task automatic test_random_windows(input int sender_pct, input int receiver_pct,
                                      input bit use_reset_settings);
      int start_count;
      if (use_reset_settings) begin
         program_meter(12'd2048, 12'd1018, 24'd658733, 24'd1319991, 16'd320, 16'd205,
                       16'd800);
      end else begin
         program_meter(CENTER_W'($urandom_range(2300, 1800)),
                       OFFSET_W'($urandom_range(1200)),
                       GAIN_W'(($urandom_range(3) == 0) ? $urandom_range(24'hFFFFFF)
                                                        : $urandom_range(1500000, 50000)),
                       GAIN_W'(($urandom_range(3) == 0) ? $urandom_range(24'hFFFFFF)
                                                        : $urandom_range(2500000, 50000)),
                       VALUE_W'($urandom_range(1500)), VALUE_W'($urandom_range(1500)),
                       VALUE_W'($urandom_range(3000)));
      end
      send_idle_pct  = sender_pct;
      recv_stall_pct = receiver_pct;
      start_count    = frames_sent;
      while (frames_sent - start_count < PHASE_FRAMES) send_random_window();
      settle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_settings();
      test_register_extremes();
      test_long_window();
      test_response_hold_off();
      test_random_windows(29, 76, 1'b0);
      test_random_windows(76, 29, 1'b0);
      test_random_windows(0, 0, 1'b1);
      $display("Run covered reset and extreme settings, a long full-scale window,");
      $display("a long response hold-off and random windows: %0d frame words, %0d results.",
               frames_sent, results_checked);
      if (error_count == 0) begin
         $display("tb_three_channel_rms_meter_core passed");
      end else begin
         $display("tb_three_channel_rms_meter_core failed");
      end
      $finish;
   end

endmodule
